FILE: rtl/core/srt_pkg.sv
`default_nettype none

package srt_pkg;

	// Number of cells in the sorted chain.
	localparam int unsigned MAX_ENTRIES = 64;

	// Width of the held count; it must reach MAX_ENTRIES itself.
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam int unsigned VAL_W = 32;
	localparam int unsigned CAP_W = 7;
	localparam int unsigned OUT_CNT_W = 7;

	// Result item: accepted, count, span_valid, shortest_span, longest_span.
	localparam int unsigned OUT_BITS = 1 + OUT_CNT_W + 1 + VAL_W + VAL_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// What one cell reports about the item offered to the chain.
	typedef struct packed {
		logic             after;     // held value sorts at or before the new value
		logic             pos;       // the new value lands in this cell
		logic             has_succ;  // this cell lands the value and holds a value
		logic [VAL_W-1:0] pred;      // left neighbor's value when pos, else zero
		logic [VAL_W-1:0] succ;      // own value when has_succ, else zero
	} cell_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/srt_cell.sv
`default_nettype none

module srt_cell (
	input  wire                           clk,
	input  wire                           load,        // an item is being inserted
	input  wire                           valid,       // this cell holds a value
	input  wire  [srt_pkg::VAL_W-1:0]     ins_value,
	input  wire                           left_after,
	input  wire  [srt_pkg::VAL_W-1:0]     left_value,
	output logic [srt_pkg::VAL_W-1:0]     value_q,
	output srt_pkg::cell_out_t            status
);

	logic after;
	logic pos;

	// A held value that is less than or equal to the new one stays put.
	assign after = valid && ($signed(value_q) <= $signed(ins_value));
	assign pos   = !after && left_after;

	always_comb begin
		status.after    = after;
		status.pos      = pos;
		status.has_succ = pos && valid;
		status.pred     = pos ? left_value : '0;
		status.succ     = (pos && valid) ? value_q : '0;
	end

	// Cells at or right of the landing cell shift one place to the right.
	always_ff @(posedge clk) begin
		if (load && !after) begin
			value_q <= left_after ? ins_value : left_value;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_min_gap_range_tracker.sv
`default_nettype none

// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata[31:0] = value
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: accepted, count, span_valid,
//                                                      shortest_span, longest_span
// cfg       in         cfg_wen (no wait)               cfg_wdata = capacity
//
// The block takes one item per cycle while the output is not stalled. Its result
// passes the stage-1 registers, then the output registers, on its way to m_axis.
// All cells of the sorted chain compare against the new value at once and
// shift in the same cycle; the gaps to the neighbors and the running minimum
// are settled in the following stage. Reset clears the count, capacity,
// minimum gap and pipeline valids; the stored values need none.
// A stalled output freezes the whole pipe, so s_axis_tready falls with it.

module sorted_min_gap_range_tracker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wen,
	input  wire  [srt_pkg::CAP_W-1:0]           cfg_wdata,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// value (32 bits, signed)
	input  wire  [srt_pkg::VAL_W-1:0]           s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// accepted (bit 0), count (7:1), span_valid (8), shortest_span (40:9),
	// longest_span (72:41), zero padding above
	output logic [srt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int unsigned N   = srt_pkg::MAX_ENTRIES;
	localparam int unsigned VW  = srt_pkg::VAL_W;
	localparam int unsigned CW  = srt_pkg::CNT_W;
	localparam int unsigned PAD = srt_pkg::OUT_TDATA_W - srt_pkg::OUT_BITS;

	// Configuration and running state.
	logic [srt_pkg::CAP_W-1:0] capacity_q;
	logic [CW-1:0]             count_q;
	logic [VW-1:0]             min_val_q;
	logic [VW-1:0]             max_val_q;
	logic [VW-1:0]             min_gap_q;

	// The whole pipe moves together unless a result waits at the output.
	logic advance;
	logic in_fire;
	logic [31:0] limit;
	logic ok;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = advance;
	assign in_fire       = s_axis_tvalid && advance;

	// Capacity above the chain length is clipped to the chain length.
	assign limit = (32'(capacity_q) > 32'(N)) ? 32'(N) : 32'(capacity_q);
	assign ok    = 32'(count_q) < limit;

	// The chain of cells. Cell 0 sees an imaginary left neighbor that is
	// always "after", so a value smaller than every held one lands there.
	logic [VW-1:0]      cell_value [N];
	srt_pkg::cell_out_t cell_stat  [N];

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic          left_after;
		logic [VW-1:0] left_value;

		if (g == 0) begin : g_head
			assign left_after = 1'b1;
			assign left_value = '0;
		end else begin : g_body
			assign left_after = cell_stat[g-1].after;
			assign left_value = cell_value[g-1];
		end

		srt_cell u_cell (
			.clk        (clk),
			.load       (in_fire && ok),
			.valid      (CW'(g) < count_q),
			.ins_value  (s_axis_tdata),
			.left_after (left_after),
			.left_value (left_value),
			.value_q    (cell_value[g]),
			.status     (cell_stat[g])
		);
	end

	// At most one cell lands the value, so its neighbors are gathered with
	// an OR over the masked cell outputs.
	logic [VW-1:0] pred_sel;
	logic [VW-1:0] succ_sel;
	logic          succ_hit;

	always_comb begin
		pred_sel = '0;
		succ_sel = '0;
		succ_hit = 1'b0;
		for (int i = 0; i < N; i++) begin
			pred_sel = pred_sel | cell_stat[i].pred;
			succ_sel = succ_sel | cell_stat[i].succ;
			succ_hit = succ_hit | cell_stat[i].has_succ;
		end
	end

	// Stage 1 registers: the item, its neighbors and the count after it.
	logic          valid_s1;
	logic          ok_s1;
	logic          has_pred_s1;
	logic          has_succ_s1;
	logic [VW-1:0] value_s1;
	logic [VW-1:0] pred_s1;
	logic [VW-1:0] succ_s1;
	logic [CW-1:0] count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			count_q    <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
			if (advance) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (in_fire && ok) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_s1       <= ok;
			value_s1    <= s_axis_tdata;
			pred_s1     <= pred_sel;
			succ_s1     <= succ_sel;
			has_pred_s1 <= cell_stat[0].after;
			has_succ_s1 <= succ_hit;
			count_s1    <= ok ? count_q + CW'(1) : count_q;
		end
		// The extremes follow every insertion, so the range is one subtract.
		if (in_fire && ok) begin
			if (count_q == '0 || $signed(s_axis_tdata) < $signed(min_val_q)) begin
				min_val_q <= s_axis_tdata;
			end
			if (count_q == '0 || $signed(s_axis_tdata) > $signed(max_val_q)) begin
				max_val_q <= s_axis_tdata;
			end
		end
	end

	// Stage 2: gaps to both neighbors fold into the running minimum. A zero
	// gap between equal values is a genuine minimum.
	logic [VW-1:0] gap_lo;
	logic [VW-1:0] gap_hi;
	logic [VW-1:0] gap_a;
	logic [VW-1:0] gap_new;
	logic          span_ok;

	assign gap_lo  = value_s1 - pred_s1;
	assign gap_hi  = succ_s1 - value_s1;
	assign gap_a   = (ok_s1 && has_pred_s1 && gap_lo < min_gap_q) ? gap_lo : min_gap_q;
	assign gap_new = (ok_s1 && has_succ_s1 && gap_hi < gap_a) ? gap_hi : gap_a;
	assign span_ok = count_s1 >= CW'(2);

	logic                 out_accepted_q;
	logic [srt_pkg::OUT_CNT_W-1:0] out_count_q;
	logic                 out_span_valid_q;
	logic [VW-1:0]        out_shortest_q;
	logic [VW-1:0]        out_longest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			min_gap_q     <= '1;
		end else if (advance) begin
			m_axis_tvalid <= valid_s1;
			if (valid_s1) begin
				min_gap_q <= gap_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_accepted_q   <= ok_s1;
			out_count_q      <= srt_pkg::OUT_CNT_W'(count_s1);
			out_span_valid_q <= span_ok;
			out_shortest_q   <= span_ok ? gap_new : '0;
			out_longest_q    <= span_ok ? (max_val_q - min_val_q) : '0;
		end
	end

	assign m_axis_tdata = {{PAD{1'b0}}, out_longest_q, out_shortest_q,
		out_span_valid_q, out_count_q, out_accepted_q};

endmodule

`default_nettype wire

FILE: verif/sorted_min_gap_range_tracker_tb.sv
`timescale 1ns / 1ps

module sorted_min_gap_range_tracker_tb;

	// One result item as it sits on m_axis_tdata, listed from the top bit down so
	// that accepted lands in bit 0.
	typedef struct packed {
		logic [srt_pkg::VAL_W-1:0]     longest_span;
		logic [srt_pkg::VAL_W-1:0]     shortest_span;
		logic                          span_valid;
		logic [srt_pkg::OUT_CNT_W-1:0] count;
		logic                          accepted;
	} span_report_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [srt_pkg::CAP_W-1:0]       cfg_wdata = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [srt_pkg::VAL_W-1:0]       s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [srt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	sorted_min_gap_range_tracker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Our own copy of the block's state: the sorted values, the running minimum
	// gap, the current spread and the capacity register.
	logic [srt_pkg::VAL_W-1:0] sorted_copy[$];
	logic [srt_pkg::VAL_W-1:0] gap_floor = '1;
	logic [srt_pkg::VAL_W-1:0] spread = '0;
	int unsigned               cap_reg = 0;

	// Results predicted but not yet seen on the output, oldest first.
	span_report_t pending_spans[$];

	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned stored_total = 0;
	int unsigned refused_total = 0;
	bit          zero_gap_seen = 1'b0;
	bit          idling_on = 1'b1;

	// Receiver control: the test asks for a long hold-off, the sink counts it.
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	// Inserts a value into the sorted copy when capacity allows, updates the gap
	// and spread, and returns the result the block must produce for it.
	function automatic span_report_t insert_and_measure(input logic [srt_pkg::VAL_W-1:0] v);
		span_report_t r;
		int unsigned  eff_cap;
		int           pos;
		logic [srt_pkg::VAL_W-1:0] gap;
		eff_cap = (cap_reg > srt_pkg::MAX_ENTRIES) ? srt_pkg::MAX_ENTRIES : cap_reg;
		r.accepted = (sorted_copy.size() < eff_cap);
		if (r.accepted) begin
			pos = 0;
			// Equal values sort after the ones already held.
			while (pos < sorted_copy.size() && $signed(sorted_copy[pos]) <= $signed(v))
				pos++;
			sorted_copy.insert(pos, v);
			if (sorted_copy.size() >= 2) begin
				// Ordered signed values give an exact unsigned difference mod 2^32.
				if (pos > 0) begin
					gap = v - sorted_copy[pos-1];
					if (gap < gap_floor)
						gap_floor = gap;
				end
				if (pos + 1 < sorted_copy.size()) begin
					gap = sorted_copy[pos+1] - v;
					if (gap < gap_floor)
						gap_floor = gap;
				end
				spread = sorted_copy[sorted_copy.size()-1] - sorted_copy[0];
			end
			stored_total++;
		end else begin
			refused_total++;
		end
		r.count = srt_pkg::OUT_CNT_W'(sorted_copy.size());
		r.span_valid = (sorted_copy.size() >= 2);
		r.shortest_span = r.span_valid ? gap_floor : '0;
		r.longest_span = r.span_valid ? spread : '0;
		return r;
	endfunction

	// Random value mix: wide values, near neighbors of held values for small gaps,
	// values close to both ends of the signed range, and small numbers around zero.
	function automatic logic [srt_pkg::VAL_W-1:0] pick_value();
		logic [srt_pkg::VAL_W-1:0] v;
		logic [srt_pkg::VAL_W-1:0] base;
		int unsigned      sel;
		int unsigned      offset;
		sel = $urandom_range(0, 99);
		if (sel < 40 || (sel < 70 && sorted_copy.size() == 0)) begin
			v = $urandom();
		end else if (sel < 70) begin
			base = sorted_copy[$urandom_range(0, sorted_copy.size() - 1)];
			offset = $urandom_range(1, 64);
			v = $urandom_range(0, 1) ? base + offset : base - offset;
		end else if (sel < 85) begin
			v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 255)
			                         : 32'h7FFF_FFFF - $urandom_range(0, 255);
		end else begin
			v = $urandom_range(0, 511) - 256;
		end
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [srt_pkg::VAL_W-1:0] got,
	                               input logic [srt_pkg::VAL_W-1:0] want);
		mismatches++;
		$display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what,
		         got, want);
	endtask

	task automatic check_result(input logic [srt_pkg::OUT_TDATA_W-1:0] bus);
		span_report_t got;
		span_report_t want;
		got = bus[srt_pkg::OUT_BITS-1:0];
		if (pending_spans.size() == 0) begin
			report_mismatch("unexpected result", srt_pkg::VAL_W'(got.count), '0);
			return;
		end
		want = pending_spans.pop_front();
		results_checked++;
		if (got.accepted !== want.accepted)
			report_mismatch("accepted", srt_pkg::VAL_W'(got.accepted),
			                srt_pkg::VAL_W'(want.accepted));
		if (got.count !== want.count)
			report_mismatch("count", srt_pkg::VAL_W'(got.count), srt_pkg::VAL_W'(want.count));
		if (got.span_valid !== want.span_valid)
			report_mismatch("span_valid", srt_pkg::VAL_W'(got.span_valid),
			                srt_pkg::VAL_W'(want.span_valid));
		if (got.shortest_span !== want.shortest_span)
			report_mismatch("shortest_span", got.shortest_span, want.shortest_span);
		if (got.longest_span !== want.longest_span)
			report_mismatch("longest_span", got.longest_span, want.longest_span);
		if (bus[srt_pkg::OUT_TDATA_W-1:srt_pkg::OUT_BITS] !== '0)
			report_mismatch("tdata padding",
			                srt_pkg::VAL_W'(bus[srt_pkg::OUT_TDATA_W-1:srt_pkg::OUT_BITS]), '0);
		if (want.span_valid && want.shortest_span == '0)
			zero_gap_seen = 1'b1;
	endtask

	// Result items are taken at the edge where tvalid and tready were both high.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			check_result(m_axis_tdata);
	end

	// Receiver: a requested long hold-off wins, then random stall bursts while
	// idling is on, otherwise always ready.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offers one item and returns at the edge that accepts it. The valid stays
	// high afterwards so that back-to-back items follow without a gap.
	task automatic send_value(input logic [srt_pkg::VAL_W-1:0] v);
		int unsigned gap_cycles;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			gap_cycles = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap_cycles) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		pending_spans.push_back(insert_and_measure(v));
	endtask

	// Ends a burst of items and waits until every predicted result has arrived,
	// then lets the two-stage pipe go quiet.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input int unsigned cap);
		cfg_wen <= 1'b1;
		cfg_wdata <= cap[srt_pkg::CAP_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		cap_reg = cap;
	endtask

	// Capacity zero refuses everything, the signed extremes included.
	task automatic test_refused_when_empty();
		write_capacity(0);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'h0000_0000);
		drain_results();
	endtask

	// One slot: the first value is held alone, so no span is valid yet.
	task automatic test_single_value();
		write_capacity(1);
		send_value(32'h7FFF_FFFF);
		send_value(32'd5);
		drain_results();
	endtask

	// The minimum lands in front of the maximum, so both spans are all ones.
	task automatic test_full_signed_gap();
		write_capacity(2);
		send_value(32'h8000_0000);
		send_value(32'd12345);
		drain_results();
	endtask

	// Middle insertions with shrinking gaps, then random values to fill up.
	task automatic test_descending_gaps();
		write_capacity(9);
		send_value(32'h0000_0000);
		send_value(32'h4000_0000);
		send_value(32'hC000_0000);
		send_value(32'h2000_0000);
		repeat (4) send_value($urandom());
		drain_results();
	endtask

	// Capacity below the count: the store keeps its values and refuses new ones.
	task automatic test_capacity_below_count();
		write_capacity(4);
		repeat (3) send_value(pick_value());
		drain_results();
	endtask

	// Bulk random traffic with idling on both sides and one long output hold-off
	// while the sender keeps offering items, so the input side must stall.
	task automatic test_random_fill();
		int i;
		write_capacity(60);
		for (i = 0; i < 300; i++) begin
			if (i == 120)
				hold_request = 40;
			send_value(pick_value());
		end
		drain_results();
	endtask

	// Duplicates of the minimum and maximum give a zero gap; 127 is clamped to the
	// chain size, checked both before and after the store is full.
	task automatic test_capacity_clamp();
		write_capacity(127);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		drain_results();
		write_capacity(64);
		send_value(32'h0000_0000);
		send_value(32'h0000_0000);
		send_value(pick_value());
		drain_results();
		write_capacity(127);
	endtask

	// Last stretch: full store, random values, no idling anywhere.
	task automatic test_back_to_back();
		idling_on = 1'b0;
		repeat (200) send_value(pick_value());
		drain_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_refused_when_empty();
		test_single_value();
		test_full_signed_gap();
		test_descending_gaps();
		test_capacity_below_count();
		test_random_fill();
		test_capacity_clamp();
		test_back_to_back();
		repeat (8) @(posedge clk);
		$display("Checked %0d results: %0d values stored, %0d refused.", results_checked,
		         stored_total, refused_total);
		$display("Capacities from zero up to a clamped 127 used; zero gap reached: %0d.",
		         zero_gap_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Far beyond the slowest correct run of 523 items with all stalls.
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still outstanding.", pending_spans.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sorted_min_gap_range_tracker.f
rtl/core/srt_pkg.sv
rtl/core/srt_cell.sv
rtl/core/sorted_min_gap_range_tracker.sv
verif/sorted_min_gap_range_tracker_tb.sv
